/* hdl/chbd_pkg.sv */
// ----------------------------------------------------------------------------
// chbd_pkg
// Shared types, character codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

   // default configuration of the size parser
   localparam int MAX_DIGITS_DEF = 8;
   localparam int SIZE_WIDTH_DEF = 32;

   // character codes
   localparam logic [7:0] CHAR_CR   = 8'h0d;
   localparam logic [7:0] CHAR_LF   = 8'h0a;
   localparam logic [7:0] CHAR_0    = 8'h30;
   localparam logic [7:0] CHAR_9    = 8'h39;
   localparam logic [7:0] CHAR_LA   = 8'h61;
   localparam logic [7:0] CHAR_LF_A = 8'h66;
   localparam logic [7:0] CHAR_UA   = 8'h41;
   localparam logic [7:0] CHAR_UF   = 8'h46;

   // request opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_EOS  = 1'b1;

   // body status codes
   localparam logic [1:0] STATUS_BUSY  = 2'd0;
   localparam logic [1:0] STATUS_DONE  = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   // parser phase
   typedef enum logic [2:0] {
      PH_SIZE = 3'd0,
      PH_EXT  = 3'd1,
      PH_DATA = 3'd2,
      PH_TAIL = 3'd3,
      PH_DONE = 3'd4
   } phase_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       pass_valid;
      logic [7:0] out_byte;
      logic       is_payload;
      logic [1:0] body_status;
   } rsp_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   // hex digit decode, both letter cases
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b0;
      h.value = 4'd0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         h.ok    = 1'b1;
         h.value = 4'(c - CHAR_0);
      end else if (c >= CHAR_LA && c <= CHAR_LF_A) begin
         h.ok    = 1'b1;
         h.value = 4'(c - CHAR_LA + 8'd10);
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         h.ok    = 1'b1;
         h.value = 4'(c - CHAR_UA + 8'd10);
      end
      return h;
   endfunction

endpackage

/* hdl/http_chunked_body_decoder_core.sv */
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Decoder for an HTTP chunked transfer-coded body, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one body byte (opcode 0) or end of stream (opcode 1) per
//            transaction; taken when req_valid is high and req_stall low.
//   rsp_*  : exactly one result per request, in order; taken when rsp_valid
//            is high and rsp_stall low.
//   csr_*  : strip_framing write port, always ready; write only while idle.
// Timing:
//   a request is held in the input register, and the parser state and the
//   result register update together when it leaves; one byte per clock is
//   sustained while the result is not stalled. The rate is set by the
//   state update between the input register and the result register.
// Stall:
//   a stalled result holds; the input register still takes one more
//   request, then req_stall rises until the result moves on.
// Reset:
//   synchronous; clears the parser to wait for size digits, empties both
//   registers and clears strip_framing.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core #(
   parameter int MAX_DIGITS = chbd_pkg::MAX_DIGITS_DEF,
   parameter int SIZE_WIDTH = chbd_pkg::SIZE_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  chbd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output chbd_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);
   import chbd_pkg::*;

   logic    held_valid;
   req_type held_data;
   logic    advance;
   rsp_type step_result;
   logic    strip_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   // held request moves when the result register is free or draining
   assign advance      = held_valid & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   chbd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   chbd_step #(
      .MAX_DIGITS (MAX_DIGITS),
      .SIZE_WIDTH (SIZE_WIDTH)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .fire          (advance),
      .item          (held_data),
      .strip_framing (strip_ff),
      .result        (step_result)
   );

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         strip_ff <= csr_data;
      end
   end

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

endmodule

/* hdl/chbd_in_reg.sv */
// ----------------------------------------------------------------------------
// chbd_in_reg
// Input register of the decoder; holds one request until the parser takes it.
// ----------------------------------------------------------------------------
module chbd_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  chbd_pkg::req_type req_data,
   input  logic              advance,
   output logic              held_valid,
   output chbd_pkg::req_type held_data
);
   import chbd_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    load;

   // stall only while a held transaction cannot move on
   assign req_stall  = valid_ff & ~advance;
   assign load       = req_valid & ~req_stall;
   assign valid_in   = load | (valid_ff & ~advance);
   assign held_valid = valid_ff;
   assign held_data  = data_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

endmodule

/* hdl/chbd_step.sv */
// ----------------------------------------------------------------------------
// chbd_step
// Chunk framing parser: state registers and the per-byte update logic.
// ----------------------------------------------------------------------------
module chbd_step #(
   parameter int MAX_DIGITS = chbd_pkg::MAX_DIGITS_DEF,
   parameter int SIZE_WIDTH = chbd_pkg::SIZE_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  chbd_pkg::req_type item,
   input  logic              strip_framing,
   output chbd_pkg::rsp_type result
);
   import chbd_pkg::*;

   phase_type             phase_ff,       phase_in;
   logic [3:0]            digit_count_ff, digit_count_in;
   logic [SIZE_WIDTH-1:0] chunk_size_ff,  chunk_size_in;
   logic [SIZE_WIDTH-1:0] chunk_seen_ff,  chunk_seen_in;
   logic                  saw_cr_ff,      saw_cr_in;
   logic                  body_done_ff,   body_done_in;
   logic                  failed_ff,      failed_in;

   logic                  pass;
   logic                  payload;
   logic [7:0]            c;
   hex_type               hex;
   logic [SIZE_WIDTH-1:0] seen_inc;

   assign c        = item.data_byte;
   assign hex      = hex_decode(c);
   assign seen_inc = chunk_seen_ff + {{(SIZE_WIDTH-1){1'b0}}, 1'b1};

   // next state
   always_comb begin
      phase_in       = phase_ff;
      digit_count_in = digit_count_ff;
      chunk_size_in  = chunk_size_ff;
      chunk_seen_in  = chunk_seen_ff;
      saw_cr_in      = saw_cr_ff;
      body_done_in   = body_done_ff;
      failed_in      = failed_ff;
      pass           = 1'b0;
      payload        = 1'b0;
      if (failed_ff || item.opcode == OP_EOS) begin
         // end of stream before completion is a truncation error
         if (!failed_ff && !body_done_ff) begin
            failed_in = 1'b1;
         end
      end else begin
         unique case (phase_ff)
            PH_SIZE: begin
               if (hex.ok) begin
                  if (digit_count_ff >= 4'(MAX_DIGITS)) begin
                     failed_in = 1'b1;
                  end else begin
                     digit_count_in = digit_count_ff + 4'd1;
                     chunk_size_in  = {chunk_size_ff[SIZE_WIDTH-5:0], hex.value};
                     pass           = 1'b1;
                  end
               end else if (digit_count_ff == 4'd0) begin
                  failed_in = 1'b1;
               end else begin
                  // size terminator; zero size ends the body
                  pass          = 1'b1;
                  chunk_seen_in = '0;
                  if (chunk_size_ff == '0) begin
                     phase_in     = PH_DONE;
                     body_done_in = 1'b1;
                  end else begin
                     phase_in  = PH_EXT;
                     saw_cr_in = (c == CHAR_CR);
                  end
               end
            end
            PH_EXT, PH_TAIL: begin
               pass = 1'b1;
               if (saw_cr_ff && c == CHAR_LF) begin
                  saw_cr_in = 1'b0;
                  if (phase_ff == PH_EXT) begin
                     chunk_seen_in = '0;
                     phase_in      = PH_DATA;
                  end else begin
                     digit_count_in = 4'd0;
                     chunk_size_in  = '0;
                     phase_in       = PH_SIZE;
                  end
               end else begin
                  saw_cr_in = (c == CHAR_CR);
               end
            end
            PH_DATA: begin
               pass          = 1'b1;
               payload       = 1'b1;
               chunk_seen_in = seen_inc;
               if (seen_inc >= chunk_size_ff) begin
                  saw_cr_in = 1'b0;
                  phase_in  = PH_TAIL;
               end
            end
            PH_DONE: begin
               pass         = 1'b1;
               body_done_in = 1'b1;
            end
            default: begin
               phase_in = PH_SIZE;
            end
         endcase
         if (pass && !payload && strip_framing) begin
            pass = 1'b0;
         end
      end
   end

   // result fields
   always_comb begin
      result.pass_valid = pass;
      result.out_byte   = pass ? c : 8'd0;
      result.is_payload = pass & payload;
      if (failed_in) begin
         result.body_status = STATUS_ERROR;
      end else if (body_done_in) begin
         result.body_status = STATUS_DONE;
      end else begin
         result.body_status = STATUS_BUSY;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SIZE;
         digit_count_ff <= 4'd0;
         chunk_size_ff  <= '0;
         chunk_seen_ff  <= '0;
         saw_cr_ff      <= 1'b0;
         body_done_ff   <= 1'b0;
         failed_ff      <= 1'b0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         digit_count_ff <= digit_count_in;
         chunk_size_ff  <= chunk_size_in;
         chunk_seen_ff  <= chunk_seen_in;
         saw_cr_ff      <= saw_cr_in;
         body_done_ff   <= body_done_in;
         failed_ff      <= failed_in;
      end
   end

endmodule

/* hdl/chbd_checker.sv */
// ----------------------------------------------------------------------------
// chbd_checker
// Port-level checks of the chunked body decoder, bound to the top level.
// ----------------------------------------------------------------------------
module chbd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input chbd_pkg::rsp_type rsp_data
);
   import chbd_pkg::*;

   logic       req_take;
   logic       rsp_take;
   logic [1:0] pending_ff, pending_in;
   logic       err_seen_ff, err_seen_in;

   assign req_take = req_valid & ~req_stall;
   assign rsp_take = rsp_valid & ~rsp_stall;

   // transactions accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_take && rsp_take) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   assign err_seen_in = err_seen_ff | (rsp_take & (rsp_data.body_status == STATUS_ERROR));

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 2'd0;
         err_seen_ff <= 1'b0;
      end else begin
         pending_ff  <= pending_in;
         err_seen_ff <= err_seen_in;
      end
   end

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // at most two transactions in flight
   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many transactions in flight");

   // request side stalls only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

   // error is sticky and forwards nothing
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && err_seen_ff |->
         rsp_data.body_status == STATUS_ERROR && !rsp_data.pass_valid)
      else $error("error status not sticky");

endmodule

bind http_chunked_body_decoder_core chbd_checker u_chbd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/tb_http_chunked_body_decoder_core.sv */
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder_core
// Self-checking bench for the chunked body decoder. A single chunked body is
// streamed after the one reset: an opening table of hand-picked bytes, then
// random chunks with random size digits, extensions, stray framing and data,
// under four sender/receiver handshake mixes with strip_framing toggled in
// between. The body ends in a zero chunk, a truncation, an empty size or an
// over-long size, picked at random. Every result is compared field by field
// with the hand-typed result of its row or else with an in-bench decoder model.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder_core;
   import chbd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIGITS  = MAX_DIGITS_DEF;
   localparam int SIZE_WIDTH  = SIZE_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MODE_ITEMS  = 190;
   localparam int TRAILER_ITEMS = 10;

   typedef enum int {
      END_ZERO_CHUNK,
      END_TRUNCATED,
      END_EMPTY_SIZE,
      END_LONG_SIZE
   } ending_type;

   // one opening row: the request, and a hand-typed result where fixed is set
   typedef struct packed {
      logic    opcode;
      logic [7:0] octet;
      logic    fixed;
      rsp_type want;
   } body_row_type;

   typedef struct packed {
      logic    fixed;
      rsp_type want;
   } row_hint_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data = 1'b0;

   // decoder model state
   phase_type             parse_phase = PH_SIZE;
   logic [3:0]            digits_taken = '0;
   logic [SIZE_WIDTH-1:0] size_acc = '0;
   logic [SIZE_WIDTH-1:0] data_count = '0;
   bit                    cr_pending = 1'b0;
   bit                    model_done = 1'b0;
   bit                    model_failed = 1'b0;
   bit                    strip_on = 1'b0;

   rsp_type      pending_results[$];
   row_hint_type row_hints[$];
   int           requests_taken = 0;
   int           results_seen = 0;
   int           items_driven = 0;
   int           mismatches = 0;
   int           cycles = 0;
   int           idle_pct = 0;
   int           stall_pct = 0;
   logic         strip_setting = 1'b0;
   ending_type   ending;

   // opening body: an eight-digit size of ten, an extension with a lone CR,
   // ten data bytes including extreme values, CR, LF and hex letters, stray tail byte
   body_row_type opening_rows [0:25] = '{
      '{OP_BYTE, CHAR_0,  1'b1, '{1'b1, CHAR_0,  1'b0, STATUS_BUSY}},
      '{OP_BYTE, CHAR_0,  1'b1, '{1'b1, CHAR_0,  1'b0, STATUS_BUSY}},
      '{OP_BYTE, CHAR_0,  1'b1, '{1'b1, CHAR_0,  1'b0, STATUS_BUSY}},
      '{OP_BYTE, CHAR_0,  1'b1, '{1'b1, CHAR_0,  1'b0, STATUS_BUSY}},
      '{OP_BYTE, CHAR_0,  1'b1, '{1'b1, CHAR_0,  1'b0, STATUS_BUSY}},
      '{OP_BYTE, CHAR_0,  1'b1, '{1'b1, CHAR_0,  1'b0, STATUS_BUSY}},
      '{OP_BYTE, CHAR_0,  1'b1, '{1'b1, CHAR_0,  1'b0, STATUS_BUSY}},
      '{OP_BYTE, CHAR_LA, 1'b1, '{1'b1, CHAR_LA, 1'b0, STATUS_BUSY}},
      '{OP_BYTE, 8'h3b,   1'b1, '{1'b1, 8'h3b,   1'b0, STATUS_BUSY}},
      '{OP_BYTE, 8'h6b,   1'b0, '0},
      '{OP_BYTE, CHAR_CR, 1'b0, '0},
      '{OP_BYTE, CHAR_CR, 1'b0, '0},
      '{OP_BYTE, CHAR_LF, 1'b0, '0},
      '{OP_BYTE, 8'h00,   1'b1, '{1'b1, 8'h00,   1'b1, STATUS_BUSY}},
      '{OP_BYTE, 8'hff,   1'b1, '{1'b1, 8'hff,   1'b1, STATUS_BUSY}},
      '{OP_BYTE, CHAR_CR, 1'b1, '{1'b1, CHAR_CR, 1'b1, STATUS_BUSY}},
      '{OP_BYTE, CHAR_LF, 1'b1, '{1'b1, CHAR_LF, 1'b1, STATUS_BUSY}},
      '{OP_BYTE, 8'h80,   1'b1, '{1'b1, 8'h80,   1'b1, STATUS_BUSY}},
      '{OP_BYTE, 8'h7f,   1'b1, '{1'b1, 8'h7f,   1'b1, STATUS_BUSY}},
      '{OP_BYTE, CHAR_UA, 1'b1, '{1'b1, CHAR_UA, 1'b1, STATUS_BUSY}},
      '{OP_BYTE, CHAR_UF, 1'b1, '{1'b1, CHAR_UF, 1'b1, STATUS_BUSY}},
      '{OP_BYTE, 8'h55,   1'b1, '{1'b1, 8'h55,   1'b1, STATUS_BUSY}},
      '{OP_BYTE, 8'haa,   1'b1, '{1'b1, 8'haa,   1'b1, STATUS_BUSY}},
      '{OP_BYTE, 8'h7a,   1'b0, '0},
      '{OP_BYTE, CHAR_CR, 1'b1, '{1'b1, CHAR_CR, 1'b0, STATUS_BUSY}},
      '{OP_BYTE, CHAR_LF, 1'b1, '{1'b1, CHAR_LF, 1'b0, STATUS_BUSY}}
   };

   int idle_pct_of  [4] = '{0, 71, 0, 18};
   int stall_pct_of [4] = '{0, 0, 71, 18};

   http_chunked_body_decoder_core #(
      .MAX_DIGITS (MAX_DIGITS),
      .SIZE_WIDTH (SIZE_WIDTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // hex digit check, upper case folded onto lower
   function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
      logic [7:0] folded;
      folded = c | 8'h20;
      v = 4'd0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         v = c[3:0];
         return 1'b1;
      end
      if (folded >= CHAR_LA && folded <= CHAR_LF_A) begin
         v = 4'(folded - CHAR_LA + 8'd10);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // random-case hex character for a nibble
   function automatic logic [7:0] hex_char(input int unsigned nib);
      if (nib < 10)
         return CHAR_0 + 8'(nib);
      return ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + 8'(nib - 10);
   endfunction

   // decoder model: advances the parse state by one transaction
   function automatic rsp_type decode_byte(input req_type r);
      rsp_type    res;
      logic [7:0] c;
      logic [3:0] nib;
      bit         fwd;
      bit         data;
      c    = r.data_byte;
      fwd  = 1'b0;
      data = 1'b0;
      if (model_failed || r.opcode == OP_EOS) begin
         if (!model_failed && !model_done)
            model_failed = 1'b1;
      end else begin
         case (parse_phase)
            PH_SIZE: begin
               if (hex_nibble(c, nib)) begin
                  if (digits_taken >= 4'(MAX_DIGITS)) begin
                     model_failed = 1'b1;
                  end else begin
                     digits_taken = digits_taken + 4'd1;
                     size_acc     = {size_acc[SIZE_WIDTH-5:0], nib};
                     fwd          = 1'b1;
                  end
               end else if (digits_taken == 4'd0) begin
                  model_failed = 1'b1;
               end else begin
                  fwd        = 1'b1;
                  data_count = '0;
                  if (size_acc == '0) begin
                     parse_phase = PH_DONE;
                     model_done  = 1'b1;
                  end else begin
                     parse_phase = PH_EXT;
                     cr_pending  = (c == CHAR_CR);
                  end
               end
            end
            PH_EXT, PH_TAIL: begin
               fwd = 1'b1;
               if (cr_pending && c == CHAR_LF) begin
                  cr_pending = 1'b0;
                  if (parse_phase == PH_EXT) begin
                     data_count  = '0;
                     parse_phase = PH_DATA;
                  end else begin
                     digits_taken = '0;
                     size_acc     = '0;
                     parse_phase  = PH_SIZE;
                  end
               end else begin
                  cr_pending = (c == CHAR_CR);
               end
            end
            PH_DATA: begin
               fwd        = 1'b1;
               data       = 1'b1;
               data_count = data_count + {{(SIZE_WIDTH-1){1'b0}}, 1'b1};
               if (data_count >= size_acc) begin
                  cr_pending  = 1'b0;
                  parse_phase = PH_TAIL;
               end
            end
            default: begin
               fwd        = 1'b1;
               model_done = 1'b1;
            end
         endcase
         if (fwd && !data && strip_on)
            fwd = 1'b0;
      end
      res.pass_valid  = fwd;
      res.out_byte    = fwd ? c : 8'd0;
      res.is_payload  = fwd && data;
      res.body_status = model_failed ? STATUS_ERROR : (model_done ? STATUS_DONE : STATUS_BUSY);
      return res;
   endfunction

   // receiver stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("http_chunked_body_decoder_core verification failed");
         $finish;
      end
   end

   // result check, request prediction, register tracking
   always @(posedge clock) begin : monitor
      rsp_type      want;
      rsp_type      got;
      row_hint_type hint;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (pending_results.size() == 0) begin
               $error("result with no transaction pending: %h", got);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (got.pass_valid !== want.pass_valid) begin
                  $error("pass_valid expected %0d got %0d", want.pass_valid, got.pass_valid);
                  mismatches++;
               end
               if (got.out_byte !== want.out_byte) begin
                  $error("out_byte expected %h got %h", want.out_byte, got.out_byte);
                  mismatches++;
               end
               if (got.is_payload !== want.is_payload) begin
                  $error("is_payload expected %0d got %0d", want.is_payload, got.is_payload);
                  mismatches++;
               end
               if (got.body_status !== want.body_status) begin
                  $error("body_status expected %0d got %0d", want.body_status,
                         got.body_status);
                  mismatches++;
               end
            end
            results_seen++;
         end
         if (req_valid && !req_stall) begin
            hint = row_hints.pop_front();
            want = decode_byte(req_data);
            pending_results.push_back(hint.fixed ? hint.want : want);
            requests_taken++;
         end
         if (csr_valid && csr_ready)
            strip_on = csr_data;
      end
   end

   // drive one transaction, with random sender gaps ahead of it
   task automatic send_item(input req_type item, input logic fixed, input rsp_type want);
      row_hints.push_back('{fixed, want});
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_driven++;
   endtask

   task automatic send_octet(input logic [7:0] b);
      send_item('{OP_BYTE, b}, 1'b0, '0);
   endtask

   // framing noise: random bytes, CRs now and then, never a bare LF
   task automatic send_noise(input int unsigned n);
      logic [7:0] b;
      repeat (n) begin
         b = ($urandom_range(0, 5) == 0) ? CHAR_CR : 8'($urandom_range(0, 255));
         if (b == CHAR_LF)
            b = 8'h2d;
         send_octet(b);
      end
   endtask

   // one chunk: size digits, terminator and extension, data, tail
   task automatic send_chunk(input int unsigned size);
      int unsigned ndig;
      int unsigned i;
      int unsigned shape;
      logic [7:0]  b;
      logic [3:0]  nib;
      ndig = 1;
      while ((size >> (4 * ndig)) != 0)
         ndig++;
      if ($urandom_range(0, 3) == 0)
         ndig = $urandom_range(ndig, MAX_DIGITS);
      for (i = ndig; i > 0; i--)
         send_octet(hex_char((size >> (4 * (i - 1))) & 4'hf));
      shape = $urandom_range(0, 3);
      if (shape != 0) begin
         if (shape == 1) begin
            b = 8'h3b;
         end else begin
            do
               b = 8'($urandom_range(0, 255));
            while (hex_nibble(b, nib) || b == CHAR_CR);
         end
         send_octet(b);
         send_noise($urandom_range(0, 6));
      end
      send_octet(CHAR_CR);
      send_octet(CHAR_LF);
      for (i = 0; i < size; i++)
         send_octet(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0)
         send_noise($urandom_range(1, 3));
      send_octet(CHAR_CR);
      send_octet(CHAR_LF);
   endtask

   // random bytes and end-of-stream marks past the end of the body
   task automatic send_trailer();
      repeat (TRAILER_ITEMS)
         send_item('{($urandom_range(0, 3) == 0) ? OP_EOS : OP_BYTE,
                     8'($urandom_range(0, 255))}, 1'b0, '0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (results_seen != requests_taken || row_hints.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_strip(input logic v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      strip_setting = v;
   endtask

   initial begin : stimulus
      int         mode;
      int         first;
      int         r;
      logic [3:0] nib;
      logic [7:0] b;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_strip(1'b0);

      // opening table
      foreach (opening_rows[k])
         send_item('{opening_rows[k].opcode, opening_rows[k].octet},
                   opening_rows[k].fixed, opening_rows[k].want);
      wait_drained();

      // random chunks under each handshake mix
      for (mode = 0; mode < 4; mode++) begin
         write_strip((mode % 2) == 0);
         idle_pct  = idle_pct_of[mode];
         stall_pct = stall_pct_of[mode];
         first = items_driven;
         while (items_driven - first < MODE_ITEMS) begin
            r = $urandom_range(0, 99);
            send_chunk(r < 85 ? $urandom_range(1, 16) :
                       (r < 98 ? $urandom_range(17, 80) : $urandom_range(200, 300)));
         end
         wait_drained();
      end

      // end of the body, one way or another
      ending = ending_type'($urandom_range(0, 3));
      write_strip(1'($urandom_range(0, 1)));
      case (ending)
         END_ZERO_CHUNK: begin
            send_chunk(0);
         end
         END_TRUNCATED: begin
            send_octet(hex_char(5));
            send_octet(CHAR_CR);
            send_octet(CHAR_LF);
            repeat ($urandom_range(0, 4))
               send_octet(8'($urandom_range(0, 255)));
            send_item('{OP_EOS, 8'($urandom_range(0, 255))}, 1'b1,
                      '{1'b0, 8'd0, 1'b0, STATUS_ERROR});
         end
         END_EMPTY_SIZE: begin
            do
               b = 8'($urandom_range(0, 255));
            while (hex_nibble(b, nib));
            send_item('{OP_BYTE, b}, 1'b1, '{1'b0, 8'd0, 1'b0, STATUS_ERROR});
         end
         default: begin
            repeat (MAX_DIGITS)
               send_octet(hex_char($urandom_range(0, 15)));
            send_item('{OP_BYTE, hex_char($urandom_range(0, 15))}, 1'b1,
                      '{1'b0, 8'd0, 1'b0, STATUS_ERROR});
         end
      endcase
      send_trailer();
      wait_drained();
      write_strip(!strip_setting);
      send_trailer();
      wait_drained();

      repeat (4) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         mismatches++;
      end
      $display("%0d requests, %0d results checked over four handshake mixes, strip on/off",
               requests_taken, results_seen);
      $display("body closed by %s, %0d mismatches", ending.name(), mismatches);
      if (mismatches == 0)
         $display("http_chunked_body_decoder_core verification clean");
      else
         $display("http_chunked_body_decoder_core verification failed");
      $finish;
   end

endmodule
